// ===== hw/rtl/tmcw_pkg.sv =====
`default_nettype none

package tmcw_pkg;

    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int COLOR_W  = 4;
    localparam int CELL_W   = CHAR_W + ATTR_W;
    localparam int OFFSET_W = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [CHAR_W-1:0] CODE_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CODE_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CODE_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CODE_NULL  = 8'h00;

    localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 1'b1;

    localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 4'd15;
    localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 4'd0;

    typedef struct packed {
        logic [1:0]        operation;
        logic [CHAR_W-1:0] character;
        logic [7:0]        column;
        logic [6:0]        row;
    } tmcw_in_t;

    typedef struct packed {
        logic [CELL_W-1:0]   cell_word;
        logic [OFFSET_W-1:0] cursor_offset;
        logic                rejected;
        logic                scrolled;
    } tmcw_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCROLL_COPY,
        ST_SCROLL_DRAIN,
        ST_SCROLL_FILL,
        ST_PUT,
        ST_CLEAR,
        ST_READ,
        ST_DONE
    } tmcw_state_t;

    typedef struct packed {
        logic load;
        logic sweep_clear;
        logic do_set;
        logic read_issue;
        logic read_capture;
        logic copy_step;
        logic fill_start;
        logic fill_step;
        logic scroll_finish;
        logic clear_step;
        logic put_exec;
        logic out_load;
    } tmcw_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       in_range;
        logic       past_end;
        logic       copy_last;
        logic       sweep_last;
        logic       out_blocked;
    } tmcw_status_t;

    // tab advance per column: 1 to tab_width positions to the next stop
    function automatic logic [255:0][4:0] tab_advance_table(input int tab_width);
        logic [255:0][4:0] t;
        int r;
        r = 0;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = 5'(tab_width - r);
            r = (r + 1 == tab_width) ? 0 : r + 1;
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tmcw_ram.sv =====
`default_nettype none

module tmcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tmcw_ctrl.sv =====
`default_nettype none

module tmcw_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire tmcw_pkg::tmcw_status_t status,
    output tmcw_pkg::tmcw_cmd_t         cmd
);

    tmcw_pkg::tmcw_state_t state_reg;
    tmcw_pkg::tmcw_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tmcw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tmcw_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tmcw_pkg::ST_DISPATCH;
                end
            end
            tmcw_pkg::ST_DISPATCH:
            begin
                case (status.op)
                    tmcw_pkg::OP_PUT:
                    begin
                        state_next = status.past_end ? tmcw_pkg::ST_SCROLL_COPY
                                                     : tmcw_pkg::ST_PUT;
                    end
                    tmcw_pkg::OP_SET:   state_next = tmcw_pkg::ST_DONE;
                    tmcw_pkg::OP_CLEAR: state_next = tmcw_pkg::ST_CLEAR;
                    tmcw_pkg::OP_READ:
                    begin
                        state_next = status.in_range ? tmcw_pkg::ST_READ
                                                     : tmcw_pkg::ST_DONE;
                    end
                    default:            state_next = tmcw_pkg::ST_DONE;
                endcase
            end
            tmcw_pkg::ST_SCROLL_COPY:
            begin
                if (status.copy_last)
                begin
                    state_next = tmcw_pkg::ST_SCROLL_DRAIN;
                end
            end
            tmcw_pkg::ST_SCROLL_DRAIN:
            begin
                state_next = tmcw_pkg::ST_SCROLL_FILL;
            end
            tmcw_pkg::ST_SCROLL_FILL:
            begin
                if (status.sweep_last)
                begin
                    state_next = tmcw_pkg::ST_PUT;
                end
            end
            tmcw_pkg::ST_PUT:   state_next = tmcw_pkg::ST_DONE;
            tmcw_pkg::ST_CLEAR:
            begin
                if (status.sweep_last)
                begin
                    state_next = tmcw_pkg::ST_DONE;
                end
            end
            tmcw_pkg::ST_READ:  state_next = tmcw_pkg::ST_DONE;
            tmcw_pkg::ST_DONE:
            begin
                if (!status.out_blocked)
                begin
                    state_next = tmcw_pkg::ST_IDLE;
                end
            end
            default:            state_next = tmcw_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            tmcw_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            tmcw_pkg::ST_DISPATCH:
            begin
                cmd.sweep_clear = 1'b1;
                cmd.do_set      = (status.op == tmcw_pkg::OP_SET);
                cmd.read_issue  = (status.op == tmcw_pkg::OP_READ);
            end
            tmcw_pkg::ST_SCROLL_COPY:  cmd.copy_step = 1'b1;
            tmcw_pkg::ST_SCROLL_DRAIN: cmd.fill_start = 1'b1;
            tmcw_pkg::ST_SCROLL_FILL:
            begin
                cmd.fill_step     = 1'b1;
                cmd.scroll_finish = status.sweep_last;
            end
            tmcw_pkg::ST_PUT:          cmd.put_exec = 1'b1;
            tmcw_pkg::ST_CLEAR:        cmd.clear_step = 1'b1;
            tmcw_pkg::ST_READ:         cmd.read_capture = 1'b1;
            tmcw_pkg::ST_DONE:         cmd.out_load = !status.out_blocked;
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tmcw_datapath.sv =====
`default_nettype none

module tmcw_datapath #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire tmcw_pkg::tmcw_in_t                in_word,
    input  wire tmcw_pkg::tmcw_cmd_t               cmd,
    output tmcw_pkg::tmcw_status_t                 status,
    input  wire logic                              cfg_write_enable,
    input  wire logic [tmcw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tmcw_pkg::COLOR_W-1:0]      cfg_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output tmcw_pkg::tmcw_out_t                    out_word
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int LIMIT      = CELL_COUNT + COLUMNS - 1;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int CW         = $clog2(LIMIT + 1);
    localparam logic [255:0][4:0] TAB_ADVANCE = tmcw_pkg::tab_advance_table(TAB_WIDTH);

    // item payload
    logic [1:0]                  op_reg;
    logic [tmcw_pkg::CHAR_W-1:0] char_reg;
    logic [7:0]                  col_in_reg;
    logic [6:0]                  row_in_reg;

    logic [CW-1:0]                cursor_reg, cursor_next;
    logic [7:0]                   col_reg, col_next;
    logic [tmcw_pkg::COLOR_W-1:0] fg_reg, fg_next;
    logic [tmcw_pkg::COLOR_W-1:0] bg_reg, bg_next;
    logic [AW-1:0]                sweep_reg, sweep_next;
    logic                         copy_valid_reg;
    logic [AW-1:0]                copy_addr_reg;
    logic [tmcw_pkg::CELL_W-1:0]  cell_reg, cell_next;
    logic                         rejected_reg, rejected_next;
    logic                         scrolled_reg, scrolled_next;
    logic                         out_valid_reg, out_valid_next;
    tmcw_pkg::tmcw_out_t          out_word_reg;

    logic [tmcw_pkg::ATTR_W-1:0] attr;
    logic [tmcw_pkg::CHAR_W-1:0] fill_code;
    logic [15:0]                 target_lin;
    logic                        in_range;
    logic                        past_end;
    logic                        is_lf, is_cr, is_tab, is_plain;
    logic [4:0]                  tab_adv;
    logic [CW:0]                 tab_sum;
    logic [9:0]                  col_sum, col_wrap1, col_wrap2;
    logic [15:0]                 cursor_wide;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr, ram_raddr;
    logic [tmcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

    tmcw_ram #(
        .WIDTH(tmcw_pkg::CELL_W),
        .DEPTH(CELL_COUNT)
    ) u_screen (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign attr       = {bg_reg, fg_reg};
    assign fill_code  = (char_reg == tmcw_pkg::CODE_NULL) ? tmcw_pkg::CODE_SPACE : char_reg;
    assign target_lin = 16'(row_in_reg) * 16'(COLUMNS) + 16'(col_in_reg);
    assign in_range   = ({1'b0, col_in_reg} < 9'(COLUMNS)) && ({1'b0, row_in_reg} < 8'(ROWS));
    assign past_end   = cursor_reg >= CW'(CELL_COUNT);

    assign is_lf    = (char_reg == tmcw_pkg::CODE_LF);
    assign is_cr    = (char_reg == tmcw_pkg::CODE_CR);
    assign is_tab   = (char_reg == tmcw_pkg::CODE_TAB);
    assign is_plain = !is_lf && !is_cr && !is_tab;

    assign tab_adv   = TAB_ADVANCE[col_reg];
    assign tab_sum   = {1'b0, cursor_reg} + (CW+1)'(tab_adv);
    assign col_sum   = 10'(col_reg) + 10'(tab_adv);
    assign col_wrap1 = (col_sum >= 10'(COLUMNS)) ? col_sum - 10'(COLUMNS) : col_sum;
    assign col_wrap2 = (col_wrap1 >= 10'(COLUMNS)) ? col_wrap1 - 10'(COLUMNS) : col_wrap1;

    assign status.op          = op_reg;
    assign status.in_range    = in_range;
    assign status.past_end    = past_end;
    assign status.copy_last   = (sweep_reg == AW'(CELL_COUNT - COLUMNS - 1));
    assign status.sweep_last  = (sweep_reg == AW'(CELL_COUNT - 1));
    assign status.out_blocked = out_valid_reg && out_stall;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = sweep_reg;
        ram_wdata = {attr, tmcw_pkg::CODE_SPACE};
        if (copy_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = copy_addr_reg;
            ram_wdata = ram_rdata;
        end
        else if (cmd.fill_step)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.clear_step)
        begin
            ram_we    = 1'b1;
            ram_wdata = {attr, fill_code};
        end
        else if (cmd.put_exec && is_plain && !past_end)
        begin
            ram_we    = 1'b1;
            ram_waddr = cursor_reg[AW-1:0];
            ram_wdata = {attr, char_reg};
        end
    end

    assign ram_raddr = cmd.copy_step ? sweep_reg + AW'(COLUMNS) : target_lin[AW-1:0];

    always_comb
    begin
        sweep_next = sweep_reg;
        if (cmd.sweep_clear)
        begin
            sweep_next = '0;
        end
        else if (cmd.fill_start)
        begin
            sweep_next = AW'(CELL_COUNT - COLUMNS);
        end
        else if (cmd.copy_step || cmd.fill_step || cmd.clear_step)
        begin
            sweep_next = sweep_reg + AW'(1);
        end
    end

    always_comb
    begin
        cursor_next = cursor_reg;
        col_next    = col_reg;
        if (cmd.do_set && in_range)
        begin
            cursor_next = target_lin[CW-1:0];
            col_next    = col_in_reg;
        end
        else if (cmd.scroll_finish)
        begin
            cursor_next = cursor_reg - CW'(COLUMNS);
        end
        else if (cmd.put_exec)
        begin
            if (is_lf)
            begin
                cursor_next = cursor_reg + CW'(COLUMNS);
            end
            else if (is_cr)
            begin
                cursor_next = cursor_reg - CW'(col_reg);
                col_next    = '0;
            end
            else if (is_tab)
            begin
                if (tab_sum > (CW+1)'(LIMIT))
                begin
                    cursor_next = CW'(LIMIT);
                    col_next    = 8'(COLUMNS - 1);
                end
                else
                begin
                    cursor_next = tab_sum[CW-1:0];
                    col_next    = col_wrap2[7:0];
                end
            end
            else
            begin
                cursor_next = cursor_reg + CW'(1);
                col_next    = (col_reg == 8'(COLUMNS - 1)) ? 8'd0 : col_reg + 8'd1;
            end
        end
    end

    always_comb
    begin
        fg_next = fg_reg;
        bg_next = bg_reg;
        if (cfg_write_enable)
        begin
            case (cfg_index)
                tmcw_pkg::REG_FOREGROUND: fg_next = cfg_data;
                tmcw_pkg::REG_BACKGROUND: bg_next = cfg_data;
                default:
                begin
                    fg_next = fg_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        cell_next     = cell_reg;
        rejected_next = rejected_reg;
        scrolled_next = scrolled_reg;
        if (cmd.load)
        begin
            cell_next     = '0;
            rejected_next = 1'b0;
            scrolled_next = 1'b0;
        end
        else
        begin
            if ((cmd.do_set || cmd.read_issue) && !in_range)
            begin
                rejected_next = 1'b1;
            end
            if (cmd.read_capture)
            begin
                cell_next = ram_rdata;
            end
            if (cmd.scroll_finish)
            begin
                scrolled_next = 1'b1;
            end
        end
    end

    assign cursor_wide = 16'(cursor_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg     <= '0;
            col_reg        <= '0;
            fg_reg         <= tmcw_pkg::FOREGROUND_RESET;
            bg_reg         <= tmcw_pkg::BACKGROUND_RESET;
            sweep_reg      <= '0;
            copy_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cursor_reg     <= cursor_next;
            col_reg        <= col_next;
            fg_reg         <= fg_next;
            bg_reg         <= bg_next;
            sweep_reg      <= sweep_next;
            copy_valid_reg <= cmd.copy_step;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_word.operation;
            char_reg   <= in_word.character;
            col_in_reg <= in_word.column;
            row_in_reg <= in_word.row;
        end
        copy_addr_reg <= sweep_reg;
        cell_reg      <= cell_next;
        rejected_reg  <= rejected_next;
        scrolled_reg  <= scrolled_next;
        if (cmd.out_load)
        begin
            out_word_reg.cell_word     <= cell_reg;
            out_word_reg.cursor_offset <= cursor_wide[tmcw_pkg::OFFSET_W-1:0];
            out_word_reg.rejected      <= rejected_reg;
            out_word_reg.scrolled      <= scrolled_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= CW'(LIMIT))
        else $error("cursor beyond limit");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, col_reg} < 9'(COLUMNS))
        else $error("column register out of range");

    a_put_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put_exec |-> !past_end)
        else $error("put executed with cursor past the last cell");

    a_write_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ({1'b0, ram_waddr} < (AW+1)'(CELL_COUNT)))
        else $error("screen write outside the store");

endmodule

`default_nettype wire

// ===== hw/rtl/text_mode_console_writer_core.sv =====
`default_nettype none

// Character console engine over a COLUMNS x ROWS screen RAM of 16-bit cells
// (attribute in 15..8, character in 7..0) with a linear cursor. One word is
// taken at a time: set cursor and a read cell that names a position off the
// screen go from dispatch straight to the result state, put character and an
// on-screen read cell first pass through their own write or read state, clear
// screen sweeps all COLUMNS*ROWS cells, and a put character that finds the
// cursor past the last cell first scrolls the screen up by one row. A result
// that is held off keeps the next accept waiting until it is taken. Clear and
// scroll run as sweeps because of the single write port of the screen RAM,
// which the scroll copy and the fills sweep one cell a cycle. The screen RAM
// is not cleared at reset; its cells are undefined until a clear or a write.
module text_mode_console_writer_core #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire tmcw_pkg::tmcw_in_t             in_word,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output tmcw_pkg::tmcw_out_t                 out_word,
    input  wire logic                           cfg_write_enable,
    input  wire logic [tmcw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tmcw_pkg::COLOR_W-1:0]   cfg_data
);

    tmcw_pkg::tmcw_cmd_t    cmd;
    tmcw_pkg::tmcw_status_t status;

    tmcw_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .status  (status),
        .cmd     (cmd)
    );

    tmcw_datapath #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_WIDTH(TAB_WIDTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_word         (in_word),
        .cmd             (cmd),
        .status          (status),
        .cfg_write_enable(cfg_write_enable),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_word        (out_word)
    );

endmodule

`default_nettype wire
